@@ rtl/assert_macros.svh @@
// assertion macros shared by the k-means core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define KMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define KMC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/kmc_pkg.sv @@
// types, codes and constants of the 2-D k-means core
package kmc_pkg;

   localparam int COORD_W          = 16;
   localparam int TAG_W            = 16;
   localparam int SLOT_W           = 10;
   localparam int KIND_W           = 3;
   localparam int CLIDX_W          = 4;
   localparam int NCL_W            = 5;
   localparam int ITER_W           = 8;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 8;
   localparam int DEF_MAX_POINTS   = 1024;
   localparam int DEF_MAX_CLUSTERS = 16;

   localparam logic [NCL_W-1:0]  NUM_CLUSTERS_RST = 5'd2;
   localparam logic [ITER_W-1:0] ITERATIONS_RST   = 8'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLUSTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATIONS   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_LOAD_PT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_CTR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RUN      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [TAG_W-1:0]          point_id;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [SLOT_W-1:0]         slot;
   } req_type;

   typedef struct packed {
      logic                      record;
      logic [TAG_W-1:0]          tag;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic [CLIDX_W-1:0]        cluster_index;
      logic                      last;
      logic                      status;
   } rsp_type;

   typedef enum logic [1:0] {
      EMIT_CTR,
      EMIT_PT,
      EMIT_ERR
   } emit_type;

   typedef struct packed {
      logic     load_pt;
      logic     load_ctr;
      logic     clear;
      logic     pt_rd;
      logic     dist_issue;
      logic     pass_clear;
      logic     accum;
      logic     div_start;
      logic     ctr_wr;
      logic     emit;
      emit_type emit_kind;
      logic     emit_last;
      logic     err_record;
   } cmd_type;

   typedef struct packed {
      logic members_nz;
      logic div_done;
      logic rsp_free;
   } stat_type;

endpackage

@@ rtl/kmc_div.sv @@
// two-lane signed by unsigned restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module kmc_div
   import kmc_pkg::*;
#(
   parameter int ACC_W = 27,
   parameter int DEN_W = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ACC_W-1:0]   num_x,
   input  logic signed [ACC_W-1:0]   num_y,
   input  logic [DEN_W-1:0]          den,
   output logic                      done,
   output logic signed [COORD_W-1:0] quot_x,
   output logic signed [COORD_W-1:0] quot_y
);

   localparam int CW = $clog2(ACC_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W-1:0] den_ff;
   logic [ACC_W-1:0] q_ff [2];
   logic [DEN_W-1:0] r_ff [2];
   logic             neg_ff [2];
   logic [ACC_W-1:0] q_in [2];
   logic [DEN_W-1:0] r_in [2];
   logic [ACC_W-1:0] mag [2];
   logic signed [ACC_W-1:0] num [2];
   logic [ACC_W-1:0] res [2];

   assign num[0] = num_x;
   assign num[1] = num_y;

   always_comb begin
      logic [DEN_W:0] shifted;
      logic [DEN_W:0] diff;
      for (int l = 0; l < 2; l++) begin
         mag[l] = num[l][ACC_W-1] ? ACC_W'(-num[l]) : ACC_W'(num[l]);
         shifted = {r_ff[l], q_ff[l][ACC_W-1]};
         diff = shifted - {1'b0, den_ff};
         if (!diff[DEN_W]) begin
            r_in[l] = diff[DEN_W-1:0];
            q_in[l] = {q_ff[l][ACC_W-2:0], 1'b1};
         end else begin
            r_in[l] = shifted[DEN_W-1:0];
            q_in[l] = {q_ff[l][ACC_W-2:0], 1'b0};
         end
         res[l] = neg_ff[l] ? ACC_W'(-q_ff[l]) : q_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ACC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         for (int l = 0; l < 2; l++) begin
            q_ff[l]   <= mag[l];
            r_ff[l]   <= '0;
            neg_ff[l] <= num[l][ACC_W-1];
         end
      end else if (busy_ff) begin
         for (int l = 0; l < 2; l++) begin
            q_ff[l] <= q_in[l];
            r_ff[l] <= r_in[l];
         end
      end
   end

   assign done   = done_ff;
   assign quot_x = res[0][COORD_W-1:0];
   assign quot_y = res[1][COORD_W-1:0];

   `KMC_ASSERT(a_div_no_restart, !(start && busy_ff), "divider started while busy")
   `KMC_ASSERT_NEXT(a_div_start_busy, start, busy_ff, "divider did not go busy")

endmodule

@@ rtl/kmc_datapath.sv @@
// point and centre stores, distance pipeline, accumulators and result register
`include "assert_macros.svh"
module kmc_datapath
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   localparam int PT_AW  = $clog2(MAX_POINTS),
   localparam int CNT_W  = PT_AW + 1,
   localparam int CL_AW  = $clog2(MAX_CLUSTERS),
   localparam int CCNT_W = CL_AW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_item,
   input  cmd_type           cmd,
   input  logic [PT_AW-1:0]  pt_addr,
   input  logic [CL_AW-1:0]  ctr_idx,
   output stat_type          stat,
   output logic [CNT_W-1:0]  pt_count,
   output logic [CCNT_W-1:0] ctr_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_item
);

   localparam int ACC_W  = COORD_W + CNT_W;
   localparam int DX_W   = COORD_W + 1;
   localparam int SQ_W   = 2 * DX_W;
   localparam int DIST_W = SQ_W + 1;

   // point store
   logic [COORD_W-1:0] pt_x_mem  [MAX_POINTS];
   logic [COORD_W-1:0] pt_y_mem  [MAX_POINTS];
   logic [TAG_W-1:0]   pt_id_mem [MAX_POINTS];
   logic [CL_AW-1:0]   pt_cl_mem [MAX_POINTS];

   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff;
   logic [TAG_W-1:0]          rd_id_ff;
   logic [CL_AW-1:0]          rd_cl_ff;

   logic [CNT_W-1:0]  pt_count_ff;
   logic [CCNT_W-1:0] ctr_count_ff;

   logic signed [COORD_W-1:0] ctr_x_ff [MAX_CLUSTERS];
   logic signed [COORD_W-1:0] ctr_y_ff [MAX_CLUSTERS];
   logic signed [ACC_W-1:0]   acc_x_ff [MAX_CLUSTERS];
   logic signed [ACC_W-1:0]   acc_y_ff [MAX_CLUSTERS];
   logic [CNT_W-1:0]          members_ff [MAX_CLUSTERS];

   // distance pipeline
   logic                   v1_ff, v2_ff;
   logic [CL_AW-1:0]       idx1_ff, idx2_ff;
   logic signed [DX_W-1:0] dx1_ff, dy1_ff;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff;
   logic [DIST_W-1:0]      best_ff, dist_sum;
   logic [CL_AW-1:0]       win_ff;

   logic                      load_pt_en, load_ctr_en, cl_we;
   logic [PT_AW-1:0]          cl_wa;
   logic [CL_AW-1:0]          cl_wd;
   logic                      div_done;
   logic signed [COORD_W-1:0] quot_x, quot_y;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign load_pt_en  = cmd.load_pt && (pt_count_ff < CNT_W'(MAX_POINTS));
   assign load_ctr_en = cmd.load_ctr && (ctr_count_ff < CCNT_W'(MAX_CLUSTERS));
   assign cl_we = cmd.accum || load_pt_en;
   assign cl_wa = cmd.accum ? pt_addr : pt_count_ff[PT_AW-1:0];
   assign cl_wd = cmd.accum ? win_ff : '0;

   always_ff @(posedge clock) begin
      if (load_pt_en) begin
         pt_x_mem[pt_count_ff[PT_AW-1:0]]  <= req_item.coord_x;
         pt_y_mem[pt_count_ff[PT_AW-1:0]]  <= req_item.coord_y;
         pt_id_mem[pt_count_ff[PT_AW-1:0]] <= req_item.point_id;
      end
      if (cl_we) begin
         pt_cl_mem[cl_wa] <= cl_wd;
      end
      if (cmd.pt_rd) begin
         rd_x_ff  <= pt_x_mem[pt_addr];
         rd_y_ff  <= pt_y_mem[pt_addr];
         rd_id_ff <= pt_id_mem[pt_addr];
         rd_cl_ff <= pt_cl_mem[pt_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_count_ff  <= '0;
         ctr_count_ff <= '0;
      end else if (cmd.clear) begin
         pt_count_ff  <= '0;
         ctr_count_ff <= '0;
      end else begin
         if (load_pt_en) begin
            pt_count_ff <= pt_count_ff + 1'b1;
         end
         if (load_ctr_en) begin
            ctr_count_ff <= ctr_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ctr_en) begin
         ctr_x_ff[ctr_count_ff[CL_AW-1:0]] <= req_item.coord_x;
         ctr_y_ff[ctr_count_ff[CL_AW-1:0]] <= req_item.coord_y;
      end else if (cmd.ctr_wr) begin
         ctr_x_ff[ctr_idx] <= quot_x;
         ctr_y_ff[ctr_idx] <= quot_y;
      end
   end

   // issue, square, then sum and compare
   assign dist_sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.dist_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= ctr_idx;
      dx1_ff  <= DX_W'(ctr_x_ff[ctr_idx]) - DX_W'(rd_x_ff);
      dy1_ff  <= DX_W'(ctr_y_ff[ctr_idx]) - DX_W'(rd_y_ff);
      idx2_ff <= idx1_ff;
      sqx_ff  <= dx1_ff * dx1_ff;
      sqy_ff  <= dy1_ff * dy1_ff;
      // strict compare keeps the lowest index on ties
      if (v2_ff && (idx2_ff == '0 || dist_sum < best_ff)) begin
         best_ff <= dist_sum;
         win_ff  <= idx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_clear) begin
         for (int j = 0; j < MAX_CLUSTERS; j++) begin
            acc_x_ff[j]   <= '0;
            acc_y_ff[j]   <= '0;
            members_ff[j] <= '0;
         end
      end else if (cmd.accum) begin
         acc_x_ff[win_ff]   <= acc_x_ff[win_ff] + ACC_W'(rd_x_ff);
         acc_y_ff[win_ff]   <= acc_y_ff[win_ff] + ACC_W'(rd_y_ff);
         members_ff[win_ff] <= members_ff[win_ff] + 1'b1;
      end
   end

   kmc_div #(
      .ACC_W (ACC_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num_x  (acc_x_ff[ctr_idx]),
      .num_y  (acc_y_ff[ctr_idx]),
      .den    (members_ff[ctr_idx]),
      .done   (div_done),
      .quot_x (quot_x),
      .quot_y (quot_y)
   );

   always_comb begin
      rsp_in = '0;
      unique case (cmd.emit_kind)
         EMIT_CTR: begin
            rsp_in.tag           = TAG_W'(ctr_idx);
            rsp_in.out_x         = ctr_x_ff[ctr_idx];
            rsp_in.out_y         = ctr_y_ff[ctr_idx];
            rsp_in.cluster_index = CLIDX_W'(ctr_idx);
            rsp_in.last          = cmd.emit_last;
         end
         EMIT_PT: begin
            rsp_in.record        = 1'b1;
            rsp_in.tag           = rd_id_ff;
            rsp_in.cluster_index = CLIDX_W'(rd_cl_ff);
            rsp_in.last          = 1'b1;
         end
         EMIT_ERR: begin
            rsp_in.record = cmd.err_record;
            rsp_in.last   = 1'b1;
            rsp_in.status = 1'b1;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.members_nz = (members_ff[ctr_idx] != '0);
   assign stat.div_done   = div_done;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pt_count  = pt_count_ff;
   assign ctr_count = ctr_count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `KMC_ASSERT(a_dp_emit_free, !cmd.emit || !rsp_valid_ff || rsp_ready,
      "result overwritten while still pending")
   `KMC_ASSERT(a_dp_div_nonzero, !cmd.div_start || members_ff[ctr_idx] != '0,
      "division started for an empty cluster")

endmodule

@@ rtl/kmc_ctrl.sv @@
// sequencer for loads, clears, reads and the assign and update passes of a run
`include "assert_macros.svh"
module kmc_ctrl
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   localparam int PT_AW  = $clog2(MAX_POINTS),
   localparam int CNT_W  = PT_AW + 1,
   localparam int CL_AW  = $clog2(MAX_CLUSTERS),
   localparam int CCNT_W = CL_AW + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  stat_type              stat,
   input  logic [CNT_W-1:0]      pt_count,
   input  logic [CCNT_W-1:0]     ctr_count,
   output cmd_type               cmd,
   output logic [PT_AW-1:0]      pt_addr,
   output logic [CL_AW-1:0]      ctr_idx
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS,
      ST_PT_RD,
      ST_DIST,
      ST_DRAIN,
      ST_ACC,
      ST_UPD,
      ST_UPD_WAIT,
      ST_OUT,
      ST_RD_OUT,
      ST_ERR_OUT
   } state_type;

   state_type         state_ff;
   logic [NCL_W-1:0]  ncl_ff;
   logic [ITER_W-1:0] iters_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [PT_AW-1:0]  i_ff;
   logic [CL_AW-1:0]  c_ff;
   logic [CCNT_W-1:0] k_ff;
   logic              drain_ff;
   logic              err_rec_ff;

   logic              accept;
   logic [CCNT_W-1:0] k_cur;
   logic              run_bad, slot_bad;
   logic              last_c, last_i, last_iter, upd_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (ncl_ff == '0) begin
         k_cur = CCNT_W'(1);
      end else if (32'(ncl_ff) > MAX_CLUSTERS) begin
         k_cur = CCNT_W'(MAX_CLUSTERS);
      end else begin
         k_cur = CCNT_W'(ncl_ff);
      end
   end

   assign run_bad   = (pt_count == '0) || (ctr_count < k_cur);
   assign slot_bad  = 32'(req_item.slot) >= 32'(pt_count);
   assign last_c    = ({1'b0, c_ff} == k_ff - 1'b1);
   assign last_i    = ({1'b0, i_ff} == pt_count - 1'b1);
   assign last_iter = (iter_ff == iters_ff - 1'b1);
   assign upd_next  = (state_ff == ST_UPD && !stat.members_nz) ||
                      (state_ff == ST_UPD_WAIT && stat.div_done);

   assign pt_addr = (state_ff == ST_IDLE) ? PT_AW'(req_item.slot) : i_ff;
   assign ctr_idx = c_ff;

   always_comb begin
      cmd = '0;
      cmd.emit_kind = EMIT_CTR;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_pt  = (req_item.kind == KIND_LOAD_PT);
               cmd.load_ctr = (req_item.kind == KIND_LOAD_CTR);
               cmd.clear    = (req_item.kind == KIND_CLEAR);
               cmd.pt_rd    = (req_item.kind == KIND_READ) && !slot_bad;
            end
         end
         ST_PASS:     cmd.pass_clear = 1'b1;
         ST_PT_RD:    cmd.pt_rd = 1'b1;
         ST_DIST:     cmd.dist_issue = 1'b1;
         ST_DRAIN:    cmd = '0;
         ST_ACC:      cmd.accum = 1'b1;
         ST_UPD:      cmd.div_start = stat.members_nz;
         ST_UPD_WAIT: cmd.ctr_wr = stat.div_done;
         ST_OUT: begin
            cmd.emit      = stat.rsp_free;
            cmd.emit_kind = EMIT_CTR;
            cmd.emit_last = last_c;
         end
         ST_RD_OUT: begin
            cmd.emit      = stat.rsp_free;
            cmd.emit_kind = EMIT_PT;
            cmd.emit_last = 1'b1;
         end
         ST_ERR_OUT: begin
            cmd.emit       = stat.rsp_free;
            cmd.emit_kind  = EMIT_ERR;
            cmd.emit_last  = 1'b1;
            cmd.err_record = err_rec_ff;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ncl_ff     <= NUM_CLUSTERS_RST;
         iters_ff   <= ITERATIONS_RST;
         iter_ff    <= '0;
         i_ff       <= '0;
         c_ff       <= '0;
         k_ff       <= '0;
         drain_ff   <= 1'b0;
         err_rec_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_NUM_CLUSTERS: ncl_ff   <= csr_wdata[NCL_W-1:0];
               CSR_ITERATIONS:   iters_ff <= csr_wdata[ITER_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_item.kind == KIND_RUN) begin
                  k_ff    <= k_cur;
                  iter_ff <= '0;
                  c_ff    <= '0;
                  if (run_bad) begin
                     err_rec_ff <= 1'b0;
                     state_ff   <= ST_ERR_OUT;
                  end else if (iters_ff == '0) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_PASS;
                  end
               end else if (accept && req_item.kind == KIND_READ) begin
                  err_rec_ff <= 1'b1;
                  state_ff   <= slot_bad ? ST_ERR_OUT : ST_RD_OUT;
               end
            end
            ST_PASS: begin
               i_ff     <= '0;
               state_ff <= ST_PT_RD;
            end
            ST_PT_RD: begin
               c_ff     <= '0;
               state_ff <= ST_DIST;
            end
            ST_DIST: begin
               if (last_c) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (last_i) begin
                  c_ff     <= '0;
                  state_ff <= ST_UPD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= ST_PT_RD;
               end
            end
            ST_UPD, ST_UPD_WAIT: begin
               if (state_ff == ST_UPD && stat.members_nz) begin
                  state_ff <= ST_UPD_WAIT;
               end else if (upd_next) begin
                  if (!last_c) begin
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= ST_UPD;
                  end else if (last_iter) begin
                     c_ff     <= '0;
                     state_ff <= ST_OUT;
                  end else begin
                     iter_ff  <= iter_ff + 1'b1;
                     state_ff <= ST_PASS;
                  end
               end
            end
            ST_OUT: begin
               if (stat.rsp_free) begin
                  if (last_c) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end
            end
            ST_RD_OUT, ST_ERR_OUT: begin
               if (stat.rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `KMC_ASSERT(a_ctrl_acc_in_range, state_ff != ST_ACC || {1'b0, i_ff} < pt_count,
      "accumulate beyond loaded points")
   `KMC_ASSERT_NEXT(a_ctrl_run_leaves_idle, accept && req_item.kind == KIND_RUN,
      state_ff != ST_IDLE, "run item did not start")

endmodule

@@ rtl/kmeans_2d_clustering_core.sv @@
// Lloyd k-means core for 2-D Q8.8 points: top level
// Usage:
// Request channel (req_valid/req_ready/req_item) carries load point, load centre,
// run, read slot and clear items. Only one item is in work at a time; req_ready
// is high while the sequencer is idle.
// Loads and clears give no result.
// A read gives one result item.
// A run uses one distance pipeline that checks one centre per cycle and a shared
// divider that delivers one quotient bit per cycle for each new centre, then gives K
// centre items, last set on the final one; a bad run gives one status item.
// Result channel (rsp_valid/rsp_ready/rsp_item) has one output register; while
// the receiver stalls, the sequencer waits and the register holds its item.
// Configuration writes (csr_wen/csr_index/csr_wdata) set the cluster count and
// pass count for the next run; the user must make them while idle, unenforced.
// Synchronous reset empties both stores, restores the register defaults and
// drops any pending result; no clearing pass is needed.
module kmeans_2d_clustering_core
   import kmc_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_item,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PT_AW  = $clog2(MAX_POINTS);
   localparam int CNT_W  = PT_AW + 1;
   localparam int CL_AW  = $clog2(MAX_CLUSTERS);
   localparam int CCNT_W = CL_AW + 1;

   cmd_type           cmd;
   stat_type          stat;
   logic [PT_AW-1:0]  pt_addr;
   logic [CL_AW-1:0]  ctr_idx;
   logic [CNT_W-1:0]  pt_count;
   logic [CCNT_W-1:0] ctr_count;

   kmc_ctrl #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .pt_count  (pt_count),
      .ctr_count (ctr_count),
      .cmd       (cmd),
      .pt_addr   (pt_addr),
      .ctr_idx   (ctr_idx)
   );

   kmc_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .pt_addr   (pt_addr),
      .ctr_idx   (ctr_idx),
      .stat      (stat),
      .pt_count  (pt_count),
      .ctr_count (ctr_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
